@@ design/mfhh_pkg.sv @@
// Package for the median-filtered hysteresis heater: widths, window geometry,
// register indexes, reset values and the sequencer state type. No dependencies.
`default_nettype none

package mfhh_pkg;

  localparam int WINDOW_LEN   = 10;
  localparam int MEDIAN_INDEX = 5;
  // Sorted position that is reported; an index past the end selects the last entry.
  localparam int MED_K  = (MEDIAN_INDEX < WINDOW_LEN) ? MEDIAN_INDEX : WINDOW_LEN - 1;
  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int RANK_W = $clog2(WINDOW_LEN + 1);

  localparam int TEMP_W     = 10;
  localparam int C16_W      = 12;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 16;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic signed [TEMP_W-1:0] LOW_THR_RESET  = 10'sd38;
  localparam logic signed [TEMP_W-1:0] HIGH_THR_RESET = 10'sd39;
  localparam logic        [DUTY_W-1:0] DUTY_RESET     = 8'd255;
  localparam logic signed [TEMP_W-1:0] LOWEST_RESET   = 10'sd257;
  localparam logic        [TEMP_W-1:0] F_OFFSET       = 10'd32;

  // floor(x / 5) == (x * RECIP_5) >> RECIP_SHIFT for every x below 2^11.
  localparam logic [15:0] RECIP_5     = 16'd52429;
  localparam int          RECIP_SHIFT = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR    = 2'd0,
    CFG_HIGH_THR   = 2'd1,
    CFG_HEAT_EN    = 2'd2,
    CFG_DRIVE_DUTY = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_WRITE,
    ST_RANK,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

@@ design/mfhh_if.sv @@
// Valid/ready channel interfaces for sample/report items and result items.
// Depends on mfhh_pkg for the field widths.
`default_nettype none

interface mfhh_item_if import mfhh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [C16_W-1:0]  temp_c16;
  logic        [TIME_W-1:0] now_ms;

  modport source (output valid, cmd, temp_c16, now_ms, input ready);
  modport sink   (input valid, cmd, temp_c16, now_ms, output ready);
endinterface

interface mfhh_result_if import mfhh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] median_f;
  logic                     heating;
  logic        [DUTY_W-1:0] drive_level;
  logic signed [TEMP_W-1:0] max_f;
  logic signed [TEMP_W-1:0] min_f;
  logic        [CNT_W-1:0]  on_count;
  logic        [TIME_W-1:0] on_time_ms;

  modport source (output valid, median_f, heating, drive_level, max_f, min_f, on_count,
                  on_time_ms, input ready);
  modport sink   (input valid, median_f, heating, drive_level, max_f, min_f, on_count,
                  on_time_ms, output ready);
endinterface

`default_nettype wire

@@ design/median_filtered_hysteresis_heater.sv @@
// Sample path: convert, write the window, rank each entry, then update and register the result;
// a report skips convert and write. A new item is taken only after the update is done.
// The item rate is bounded mainly by the rank unit, which scores one window entry per cycle.
// A finished result waits in the output register while the next item is worked on.
// Synchronous active-high reset clears the window to zero, the heater and statistics,
// sets the minimum to 257 and loads the register reset values.
`default_nettype none

module median_filtered_hysteresis_heater import mfhh_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mfhh_item_if.sink                  item,
  mfhh_result_if.source              result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic signed [TEMP_W-1:0] low_thr, high_thr;
  logic                     heat_en;
  logic        [DUTY_W-1:0] duty;

  logic signed [TEMP_W-1:0] window [WINDOW_LEN];
  logic        [IDX_W-1:0]  write_slot;
  logic                     heater_on;
  logic        [TIME_W-1:0] on_start;
  logic        [CNT_W-1:0]  turn_on_count;
  logic        [TIME_W-1:0] on_time_sum;
  logic signed [TEMP_W-1:0] highest_f, lowest_f;

  logic                     cmd_reg;
  logic signed [C16_W-1:0]  temp_reg;
  logic        [TIME_W-1:0] now_reg;
  logic        [26:0]       conv_prod;
  logic                     conv_neg;
  logic        [IDX_W-1:0]  cand_idx;
  logic signed [TEMP_W-1:0] med_reg;
  logic        [TIME_W-1:0] elapsed;

  logic accept, conv_en, write_en, rank_en, upd_fire, rank_last;

  assign accept    = item.valid && item.ready;
  assign rank_last = (cand_idx == IDX_W'(WINDOW_LEN - 1));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = item.cmd ? ST_RANK : ST_CONV;
      ST_CONV:   state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_RANK;
      ST_RANK:   if (rank_last) state_next = ST_UPDATE;
      ST_UPDATE: if (!result.valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    conv_en    = 1'b0;
    write_en   = 1'b0;
    rank_en    = 1'b0;
    upd_fire   = 1'b0;
    unique case (state)
      ST_IDLE:   item.ready = 1'b1;
      ST_CONV:   conv_en = 1'b1;
      ST_WRITE:  write_en = 1'b1;
      ST_RANK:   rank_en = 1'b1;
      ST_UPDATE: upd_fire = !result.valid || result.ready;
      default:   item.ready = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr  <= LOW_THR_RESET;
      high_thr <= HIGH_THR_RESET;
      heat_en  <= 1'b1;
      duty     <= DUTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LOW_THR:    low_thr  <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_HIGH_THR:   high_thr <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_HEAT_EN:    heat_en  <= cfg_data[0];
        CFG_DRIVE_DUTY: duty     <= cfg_data[DUTY_W-1:0];
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg  <= item.cmd;
      temp_reg <= item.temp_c16;
      now_reg  <= item.now_ms;
    end
  end

  // Conversion: F = trunc(c16 * 9 / 80) + 32, done on the magnitude as (|9c| >> 4) / 5.
  logic signed [15:0]       prod9;
  logic        [14:0]       mag9;
  logic        [8:0]        quot;
  logic signed [TEMP_W-1:0] conv_f;

  always_comb begin
    prod9  = (16'(temp_reg) <<< 3) + 16'(temp_reg);
    mag9   = prod9[15] ? 15'(-prod9) : prod9[14:0];
    quot   = conv_prod[RECIP_SHIFT +: 9];
    conv_f = conv_neg ? $signed(F_OFFSET - 10'(quot)) : $signed(F_OFFSET + 10'(quot));
  end

  always_ff @(posedge clk) begin
    if (conv_en) begin
      conv_prod <= 27'(mag9[14:4]) * 27'(RECIP_5);
      conv_neg  <= prod9[15];
    end
  end

  // Rank unit: the candidate's sorted position is the number of entries below it,
  // with equal entries ordered by slot so that every position is taken exactly once.
  logic signed [TEMP_W-1:0] cand;
  logic        [RANK_W-1:0] rank;

  always_comb begin
    cand = window[cand_idx];
    rank = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if ((window[j] < cand) || ((window[j] == cand) && (IDX_W'(j) < cand_idx))) begin
        rank = rank + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_idx <= '0;
    end else if (rank_en) begin
      cand_idx <= rank_last ? '0 : cand_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rank_en) begin
      if (rank == RANK_W'(MED_K)) med_reg <= cand;
      elapsed <= now_reg - on_start;
    end
  end

  // Heater and statistics update.
  logic                     low_hit, high_hit, turned_on, add_now;
  logic        [TIME_W:0]   sum_add;
  logic        [TIME_W-1:0] sum_sat;
  logic                     heater_next;
  logic        [TIME_W-1:0] start_next, sum_next, rpt_time;
  logic        [CNT_W-1:0]  count_next, rpt_count;
  logic signed [TEMP_W-1:0] highest_next, lowest_next;

  always_comb begin
    low_hit      = (med_reg <= low_thr);
    high_hit     = (med_reg >= high_thr);
    sum_add      = {1'b0, on_time_sum} + {1'b0, elapsed};
    sum_sat      = sum_add[TIME_W] ? '1 : sum_add[TIME_W-1:0];
    turned_on    = 1'b0;
    add_now      = 1'b0;
    heater_next  = heater_on;
    start_next   = on_start;
    count_next   = turn_on_count;
    sum_next     = on_time_sum;
    highest_next = highest_f;
    lowest_next  = lowest_f;
    rpt_count    = turn_on_count;
    rpt_time     = on_time_sum;
    if (!cmd_reg) begin
      turned_on = low_hit && heat_en && !heater_on;
      // A heater just turned on and switched off by the same sample gains no time.
      add_now   = heater_on && ((low_hit && !heat_en) || high_hit);
      if (turned_on) begin
        heater_next = !high_hit;
        start_next  = now_reg;
        if (turn_on_count != '1) count_next = turn_on_count + CNT_W'(1);
      end else if (add_now) begin
        heater_next = 1'b0;
        sum_next    = sum_sat;
      end
      if (med_reg > highest_f) highest_next = med_reg;
      if (med_reg < lowest_f) lowest_next = med_reg;
      rpt_count = count_next;
      rpt_time  = sum_next;
    end else begin
      if (heater_on) begin
        rpt_time   = sum_sat;
        start_next = now_reg;
      end
      count_next = '0;
      sum_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) window[i] <= '0;
      write_slot    <= '0;
      heater_on     <= 1'b0;
      on_start      <= '0;
      turn_on_count <= '0;
      on_time_sum   <= '0;
      highest_f     <= '0;
      lowest_f      <= LOWEST_RESET;
    end else begin
      if (write_en) begin
        window[write_slot] <= conv_f;
        write_slot <= (write_slot == IDX_W'(WINDOW_LEN - 1)) ? '0 : write_slot + IDX_W'(1);
      end
      if (upd_fire) begin
        heater_on     <= heater_next;
        on_start      <= start_next;
        turn_on_count <= count_next;
        on_time_sum   <= sum_next;
        highest_f     <= highest_next;
        lowest_f      <= lowest_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (upd_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      result.median_f    <= med_reg;
      result.heating     <= heater_next;
      result.drive_level <= heater_next ? duty : '0;
      result.max_f       <= highest_next;
      result.min_f       <= lowest_next;
      result.on_count    <= rpt_count;
      result.on_time_ms  <= rpt_time;
    end
  end

endmodule

`default_nettype wire

@@ design/mfhh_checker.sv @@
// Port-level checks for the median-filtered hysteresis heater, bound to its top level.
// Depends on mfhh_pkg and the channel interfaces of the top level.
`default_nettype none

module mfhh_checker import mfhh_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     item_valid,
  input wire logic                     item_ready,
  input wire logic                     result_valid,
  input wire logic                     result_ready,
  input wire logic                     heating,
  input wire logic        [DUTY_W-1:0] drive_level,
  input wire logic        [CNT_W-1:0]  on_count,
  input wire logic        [TIME_W-1:0] on_time_ms
);

  // A waiting result beat keeps its turn-on count and on-time total.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(on_count) && $stable(on_time_ms))
    else $error("result beat changed while stalled");

  // Once the block takes an item, ready stays low while that item is in work.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous item still in work");

  // No result can come out right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result appeared one cycle after an item was taken");

  // The heater drive is zero whenever the heater is reported off.
  a_drive_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && !heating |-> drive_level == '0)
    else $error("drive level nonzero while heater off");

endmodule

bind median_filtered_hysteresis_heater mfhh_checker u_mfhh_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .heating      (result.heating),
  .drive_level  (result.drive_level),
  .on_count     (result.on_count),
  .on_time_ms   (result.on_time_ms)
);

`default_nettype wire
